// ===== rtl/ucrr_pkg.sv =====
// Package for the USB control request responder: codes, types and string descriptor tables.
// No dependencies.
package ucrr_pkg;
   localparam int MAX_PACKET_DEF = 64;
   localparam int STRING_COUNT_DEF = 5;
   localparam int STRING_MAX_CHARS_DEF = 8;
   localparam int TABLE_STRINGS = 5;
   localparam int CONFIG_TOTAL = 32;

   typedef enum logic [2:0] {
      ACT_SETUP = 3'd0, ACT_BUS_RESET = 3'd1, ACT_EP0_IN_DONE = 3'd2,
      ACT_BULK_OUT_DONE = 3'd3, ACT_BULK_IN_DONE = 3'd4, ACT_ARM_BULK_OUT = 3'd5,
      ACT_RSVD6 = 3'd6, ACT_RSVD7 = 3'd7
   } action_type;

   localparam logic [2:0] CSR_VENDOR_ID = 3'd0;
   localparam logic [2:0] CSR_PRODUCT_ID = 3'd1;
   localparam logic [2:0] CSR_DEVICE_RELEASE = 3'd2;
   localparam logic [2:0] CSR_CONFIG_ATTR = 3'd3;
   localparam logic [2:0] CSR_MAX_POWER = 3'd4;

   localparam logic [7:0] RT_HOST_TO_DEV = 8'h00;
   localparam logic [7:0] RT_DEV_TO_HOST = 8'h80;
   localparam logic [7:0] REQ_SET_ADDRESS = 8'd5;
   localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
   localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
   localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;
   localparam logic [7:0] DESC_DEVICE = 8'd1;
   localparam logic [7:0] DESC_CONFIG = 8'd2;
   localparam logic [7:0] DESC_STRING = 8'd3;

   localparam logic [1:0] EP_EP0_OUT = 2'd0;
   localparam logic [1:0] EP_EP0_IN = 2'd1;
   localparam logic [1:0] EP_BULK_OUT = 2'd2;
   localparam logic [1:0] EP_BULK_IN = 2'd3;

   typedef enum logic [1:0] {
      SRC_DEVICE = 2'd0, SRC_CONFIG = 2'd1, SRC_STRING = 2'd2, SRC_ONE = 2'd3
   } source_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0, ST_STREAM = 2'd1, ST_SINGLE = 2'd2
   } state_type;

   typedef struct packed {
      logic       load;
      logic       advance;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic       stream;
      logic       single;
      logic       at_end;
   } status_type;

   typedef struct packed {
      logic [1:0] endpoint;
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       arm_buffer;
      logic [6:0] transfer_length;
      logic       data_pid;
      logic       buffer_full;
      logic       address_apply;
      logic [7:0] dev_addr;
      logic       configured;
      logic       last;
   } result_type;

   function automatic logic [7:0] str_char(input logic [2:0] s, input logic [2:0] c);
      logic [7:0] t [0:TABLE_STRINGS-1][0:7];
      t[0] = '{8'h50, 8'h69, 8'h63, 8'h6f, 8'h55, 8'h53, 8'h42, 8'h00};
      t[1] = '{8'h44, 8'h65, 8'h6d, 8'h6f, 8'h00, 8'h00, 8'h00, 8'h00};
      t[2] = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h00, 8'h00, 8'h00};
      t[3] = '{8'h45, 8'h61, 8'h73, 8'h79, 8'h00, 8'h00, 8'h00, 8'h00};
      t[4] = '{8'h53, 8'h69, 8'h6d, 8'h70, 8'h6c, 8'h65, 8'h00, 8'h00};
      if (s < 3'(TABLE_STRINGS)) str_char = t[s][c];
      else str_char = 8'h00;
   endfunction

   function automatic logic [3:0] str_len(input logic [2:0] s);
      unique case (s)
         3'd0: str_len = 4'd7;
         3'd1: str_len = 4'd4;
         3'd2: str_len = 4'd5;
         3'd3: str_len = 4'd4;
         3'd4: str_len = 4'd6;
         default: str_len = 4'd0;
      endcase
   endfunction
endpackage

// ===== rtl/ucrr_if.sv =====
// Valid/ready channel interfaces for the responder's request, response and CSR ports.
// No dependencies.
interface ucrr_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [7:0]  request_type;
   logic [7:0]  request_code;
   logic [15:0] request_value;
   logic [15:0] length_requested;
   logic [6:0]  received_length;
   modport source (output valid, action, request_type, request_code, request_value,
      length_requested, received_length, input ready);
   modport sink (input valid, action, request_type, request_code, request_value,
      length_requested, received_length, output ready);
endinterface

interface ucrr_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  endpoint;
   logic [7:0]  data_byte;
   logic        byte_valid;
   logic        arm_buffer;
   logic [6:0]  transfer_length;
   logic        data_pid;
   logic        buffer_full;
   logic        address_apply;
   logic [7:0]  dev_addr;
   logic        configured;
   logic        last;
   modport source (output valid, endpoint, data_byte, byte_valid, arm_buffer,
      transfer_length, data_pid, buffer_full, address_apply, dev_addr,
      configured, last, input ready);
   modport sink (input valid, endpoint, data_byte, byte_valid, arm_buffer,
      transfer_length, data_pid, buffer_full, address_apply, dev_addr,
      configured, last, output ready);
endinterface

interface ucrr_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/usb_control_request_responder.sv =====
// Top level of the USB control request responder: joins controller and datapath to the ports.
// Depends on ucrr_pkg, ucrr_if, ucrr_ctrl and ucrr_datapath.
// One request item is taken when the block is idle. Descriptor and configuration
// replies stream one byte result per cycle from the datapath's ROM while the response
// side accepts them; other items give one result or none. The next item is taken in
// the cycle after the last result is accepted.
// Configuration writes are taken at any time and should be made while idle.
module usb_control_request_responder #(
   parameter int MAX_PACKET = ucrr_pkg::MAX_PACKET_DEF,
   parameter int STRING_COUNT = ucrr_pkg::STRING_COUNT_DEF,
   parameter int STRING_MAX_CHARS = ucrr_pkg::STRING_MAX_CHARS_DEF
) (
   input logic     clock,
   input logic     reset,
   ucrr_req_if.sink   req,
   ucrr_rsp_if.source rsp,
   ucrr_csr_if.sink   csr
);
   import ucrr_pkg::*;

   cmd_type    cmd;
   status_type status;
   result_type result;

   assign csr.ready = 1'b1;

   ucrr_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req.valid), .req_ready(req.ready),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .status(status), .cmd(cmd)
   );

   ucrr_datapath #(
      .MAX_PACKET(MAX_PACKET), .STRING_COUNT(STRING_COUNT),
      .STRING_MAX_CHARS(STRING_MAX_CHARS)
   ) u_datapath (
      .clock(clock), .reset(reset),
      .csr_we(csr.valid), .csr_index(csr.index), .csr_data(csr.data),
      .action(req.action), .request_type(req.request_type),
      .request_code(req.request_code), .request_value(req.request_value),
      .length_requested(req.length_requested), .received_length(req.received_length),
      .cmd(cmd), .status(status), .result(result)
   );

   assign rsp.endpoint = result.endpoint;
   assign rsp.data_byte = result.data_byte;
   assign rsp.byte_valid = result.byte_valid;
   assign rsp.arm_buffer = result.arm_buffer;
   assign rsp.transfer_length = result.transfer_length;
   assign rsp.data_pid = result.data_pid;
   assign rsp.buffer_full = result.buffer_full;
   assign rsp.address_apply = result.address_apply;
   assign rsp.dev_addr = result.dev_addr;
   assign rsp.configured = result.configured;
   assign rsp.last = result.last;
endmodule

// ===== rtl/ucrr_ctrl.sv =====
// Controller state machine of the responder: sequences item intake and result streaming.
// Depends on ucrr_pkg.
module ucrr_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  ucrr_pkg::status_type status,
   output ucrr_pkg::cmd_type    cmd
);
   import ucrr_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.stream) state_in = ST_STREAM;
               else if (status.single) state_in = ST_SINGLE;
            end
         end
         ST_STREAM: begin
            rsp_valid = 1'b1;
            cmd.emit = 1'b1;
            if (rsp_ready) begin
               cmd.advance = 1'b1;
               if (status.at_end) state_in = ST_IDLE;
            end
         end
         ST_SINGLE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule

// ===== rtl/ucrr_datapath.sv =====
// Datapath of the responder: CSRs, device state, decode of items and descriptor bytes.
// Depends on ucrr_pkg.
module ucrr_datapath #(
   parameter int MAX_PACKET = ucrr_pkg::MAX_PACKET_DEF,
   parameter int STRING_COUNT = ucrr_pkg::STRING_COUNT_DEF,
   parameter int STRING_MAX_CHARS = ucrr_pkg::STRING_MAX_CHARS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_data,
   input  logic [2:0]           action,
   input  logic [7:0]           request_type,
   input  logic [7:0]           request_code,
   input  logic [15:0]          request_value,
   input  logic [15:0]          length_requested,
   input  logic [6:0]           received_length,
   input  ucrr_pkg::cmd_type    cmd,
   output ucrr_pkg::status_type status,
   output ucrr_pkg::result_type result
);
   import ucrr_pkg::*;

   localparam logic [6:0] MAXP = 7'(MAX_PACKET);
   localparam int CHARW = (STRING_MAX_CHARS < TABLE_STRINGS + 3) ? STRING_MAX_CHARS : 8;

   logic [15:0] vendor_id_ff, product_id_ff, device_release_ff;
   logic [7:0]  config_attr_ff, max_power_ff;
   logic [3:0]  toggle_ff;
   logic [7:0]  pending_addr_ff;
   logic        addr_pending_ff;
   logic        configured_ff;
   logic [5:0]  pos_ff;
   logic [6:0]  count_ff;
   source_type  src_ff;
   logic [2:0]  str_ff;
   logic        pid_ff;
   result_type  single_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vendor_id_ff <= 16'd0;
         product_id_ff <= 16'd1;
         device_release_ff <= 16'd1;
         config_attr_ff <= 8'hc0;
         max_power_ff <= 8'd50;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_VENDOR_ID: vendor_id_ff <= csr_data;
            CSR_PRODUCT_ID: product_id_ff <= csr_data;
            CSR_DEVICE_RELEASE: device_release_ff <= csr_data;
            CSR_CONFIG_ATTR: config_attr_ff <= csr_data[7:0];
            CSR_MAX_POWER: max_power_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // Decode of the incoming item.
   logic [7:0]  kind, idx;
   logic        do_stream, do_single, no_reply;
   logic [6:0]  full_len, n_len;
   source_type  src_sel;
   logic [3:0]  chars;
   logic [1:0]  arm_ep;
   logic [6:0]  arm_len;
   logic        is_arm, is_apply, store_addr, set_cfg, clr_state, use_pending;
   result_type  single_in;

   always_comb begin
      kind = request_value[15:8];
      idx = request_value[7:0];
      no_reply = 1'b0;
      full_len = 7'd0;
      src_sel = SRC_DEVICE;
      chars = str_len(3'(idx - 8'd1));
      if (chars > 4'(CHARW)) chars = 4'(CHARW);
      is_arm = 1'b0;
      is_apply = 1'b0;
      arm_ep = EP_EP0_OUT;
      arm_len = 7'd0;
      store_addr = 1'b0;
      set_cfg = 1'b0;
      clr_state = 1'b0;
      use_pending = 1'b0;
      do_stream = 1'b0;
      unique case (action)
         ACT_SETUP: begin
            if (request_type == RT_HOST_TO_DEV) begin
               is_arm = 1'b1;
               arm_ep = EP_EP0_IN;
               store_addr = (request_code == REQ_SET_ADDRESS);
               set_cfg = (request_code == REQ_SET_CONFIGURATION);
            end else if (request_type == RT_DEV_TO_HOST &&
                         request_code == REQ_GET_CONFIGURATION) begin
               full_len = 7'd1;
               src_sel = SRC_ONE;
               do_stream = 1'b1;
            end else if (request_type == RT_DEV_TO_HOST &&
                         request_code == REQ_GET_DESCRIPTOR) begin
               do_stream = 1'b1;
               if (kind == DESC_DEVICE) begin
                  full_len = 7'd18;
               end else if (kind == DESC_CONFIG) begin
                  full_len = 7'(CONFIG_TOTAL);
                  src_sel = SRC_CONFIG;
               end else if (kind == DESC_STRING) begin
                  src_sel = SRC_STRING;
                  if (idx == 8'd0) full_len = 7'd4;
                  else if (idx > 8'(STRING_COUNT) || idx > 8'(TABLE_STRINGS)) no_reply = 1'b1;
                  else full_len = 7'd2 + {2'b0, chars, 1'b0};
               end else begin
                  no_reply = 1'b1;
               end
            end
         end
         ACT_BUS_RESET: begin
            is_apply = 1'b1;
            clr_state = 1'b1;
         end
         ACT_EP0_IN_DONE: begin
            if (addr_pending_ff) begin
               is_apply = 1'b1;
               use_pending = 1'b1;
            end else begin
               is_arm = 1'b1;
            end
         end
         ACT_BULK_OUT_DONE: begin
            is_arm = 1'b1;
            arm_ep = EP_BULK_IN;
            arm_len = (received_length > MAXP) ? MAXP : received_length;
         end
         ACT_BULK_IN_DONE, ACT_ARM_BULK_OUT: begin
            is_arm = 1'b1;
            arm_ep = EP_BULK_OUT;
            arm_len = MAXP;
         end
         default: ;
      endcase
      if (no_reply) do_stream = 1'b0;
      n_len = full_len;
      if ({9'd0, n_len} > length_requested) n_len = length_requested[6:0];
      if (n_len > MAXP) n_len = MAXP;
      // A zero-length reply becomes a single arming of EP0 IN.
      if (do_stream && n_len == 7'd0) begin
         do_stream = 1'b0;
         is_arm = 1'b1;
         arm_ep = EP_EP0_IN;
      end
      do_single = is_arm | is_apply;
      single_in = '0;
      single_in.last = 1'b1;
      single_in.configured = ~clr_state & (configured_ff | set_cfg);
      if (is_arm) begin
         single_in.endpoint = arm_ep;
         single_in.arm_buffer = 1'b1;
         single_in.transfer_length = arm_len;
         single_in.data_pid = (arm_ep == EP_EP0_IN && action == ACT_SETUP) ? 1'b1
                              : toggle_ff[arm_ep];
         single_in.buffer_full = arm_ep[0];
      end else begin
         single_in.endpoint = use_pending ? EP_EP0_IN : EP_EP0_OUT;
         single_in.address_apply = 1'b1;
         single_in.dev_addr = use_pending ? pending_addr_ff : 8'd0;
      end
      status.stream = do_stream;
      status.single = do_single;
      status.at_end = ({1'b0, pos_ff} + 7'd1 == count_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         toggle_ff <= 4'd0;
         pending_addr_ff <= 8'd0;
         addr_pending_ff <= 1'b0;
         configured_ff <= 1'b0;
      end else if (cmd.load) begin
         if (action == ACT_SETUP) toggle_ff[EP_EP0_IN] <= 1'b1;
         if (store_addr) begin
            pending_addr_ff <= idx;
            addr_pending_ff <= 1'b1;
         end
         if (set_cfg) configured_ff <= 1'b1;
         if (clr_state) begin
            pending_addr_ff <= 8'd0;
            addr_pending_ff <= 1'b0;
            configured_ff <= 1'b0;
         end
         if (use_pending) addr_pending_ff <= 1'b0;
         if (is_arm) toggle_ff[arm_ep] <= ~single_in.data_pid;
         if (do_stream) toggle_ff[EP_EP0_IN] <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pos_ff <= 6'd0;
         count_ff <= n_len;
         src_ff <= src_sel;
         str_ff <= 3'(idx);
         pid_ff <= 1'b1;
         single_ff <= single_in;
      end else if (cmd.advance) begin
         pos_ff <= pos_ff + 6'd1;
      end
   end

   // Byte at the current stream position.
   logic [7:0] byte_val;
   logic [3:0] slen;
   always_comb begin
      byte_val = 8'd0;
      slen = str_len(str_ff - 3'd1);
      if (slen > 4'(CHARW)) slen = 4'(CHARW);
      unique case (src_ff)
         SRC_ONE: byte_val = 8'd1;
         SRC_DEVICE: begin
            case (pos_ff)
               6'd0: byte_val = 8'd18;
               6'd1: byte_val = 8'h01;
               6'd3: byte_val = 8'h02;
               6'd7: byte_val = 8'(MAX_PACKET);
               6'd8: byte_val = vendor_id_ff[7:0];
               6'd9: byte_val = vendor_id_ff[15:8];
               6'd10: byte_val = product_id_ff[7:0];
               6'd11: byte_val = product_id_ff[15:8];
               6'd12: byte_val = device_release_ff[7:0];
               6'd13: byte_val = device_release_ff[15:8];
               6'd14: byte_val = 8'd1;
               6'd15: byte_val = 8'd2;
               6'd16: byte_val = 8'd3;
               6'd17: byte_val = 8'd1;
               default: byte_val = 8'd0;
            endcase
         end
         SRC_CONFIG: begin
            case (pos_ff)
               6'd0: byte_val = 8'd9;
               6'd1: byte_val = 8'h02;
               6'd2: byte_val = 8'(CONFIG_TOTAL);
               6'd4: byte_val = 8'd1;
               6'd5: byte_val = 8'd1;
               6'd6: byte_val = 8'd4;
               6'd7: byte_val = config_attr_ff;
               6'd8: byte_val = max_power_ff;
               6'd9: byte_val = 8'd9;
               6'd10: byte_val = 8'h04;
               6'd13: byte_val = 8'd2;
               6'd14: byte_val = 8'hff;
               6'd17: byte_val = 8'd5;
               6'd18: byte_val = 8'd7;
               6'd19: byte_val = 8'h05;
               6'd20: byte_val = 8'h01;
               6'd21: byte_val = 8'h02;
               6'd22: byte_val = 8'(MAX_PACKET);
               6'd25: byte_val = 8'd7;
               6'd26: byte_val = 8'h05;
               6'd27: byte_val = 8'h82;
               6'd28: byte_val = 8'h02;
               6'd29: byte_val = 8'(MAX_PACKET);
               default: byte_val = 8'd0;
            endcase
         end
         SRC_STRING: begin
            if (str_ff == 3'd0) begin
               case (pos_ff)
                  6'd0: byte_val = 8'd4;
                  6'd1: byte_val = 8'h03;
                  6'd2: byte_val = 8'h09;
                  6'd3: byte_val = 8'h04;
                  default: byte_val = 8'd0;
               endcase
            end else if (pos_ff == 6'd0) begin
               byte_val = 8'd2 + {3'd0, slen, 1'b0};
            end else if (pos_ff == 6'd1) begin
               byte_val = 8'h03;
            end else if (!pos_ff[0]) begin
               byte_val = str_char(str_ff - 3'd1, 3'((pos_ff - 6'd2) >> 1));
            end
         end
         default: byte_val = 8'd0;
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         result = '0;
         result.endpoint = EP_EP0_IN;
         result.data_byte = byte_val;
         result.byte_valid = 1'b1;
         result.configured = configured_ff;
         if (status.at_end) begin
            result.arm_buffer = 1'b1;
            result.transfer_length = count_ff;
            result.data_pid = pid_ff;
            result.buffer_full = 1'b1;
            result.last = 1'b1;
         end
      end else begin
         result = single_ff;
      end
   end
endmodule

// ===== tb/tb_usb_control_request_responder.sv =====
// Testbench for usb_control_request_responder: drives request items, predicts every
// response item from a behavioral copy of the responder and checks them in order.
// Depends on ucrr_pkg, ucrr_if and the responder RTL.
module tb_usb_control_request_responder;
   import ucrr_pkg::*;

   typedef struct packed {
      logic [2:0]  action;
      logic [7:0]  request_type;
      logic [7:0]  request_code;
      logic [15:0] request_value;
      logic [15:0] length_requested;
      logic [6:0]  received_length;
   } request_item;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int cycle_count = 0;
   int errors = 0;
   bit hold_requests = 1'b0;
   bit req_accepted = 1'b0;

   ucrr_req_if req ();
   ucrr_rsp_if rsp ();
   ucrr_csr_if csr ();

   usb_control_request_responder dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   request_item pending_requests [$];
   result_type expected_results [$];

   logic toggle [0:3];
   logic [7:0] saved_address;
   logic address_waiting;
   logic is_configured;
   logic [15:0] vid, pid_reg, release_bcd;
   logic [7:0] attr_byte, power_byte;

   function automatic result_type make_result(logic [1:0] ep, logic [7:0] b, logic bv,
      logic arm, logic [6:0] len, logic pid, logic full, logic apply, logic [7:0] addr);
      result_type r;
      r.endpoint = ep; r.data_byte = b; r.byte_valid = bv; r.arm_buffer = arm;
      r.transfer_length = len; r.data_pid = pid; r.buffer_full = full;
      r.address_apply = apply; r.dev_addr = addr; r.configured = is_configured;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic void arm_endpoint(logic [1:0] ep, logic [6:0] len);
      logic p;
      p = toggle[ep];
      toggle[ep] = ~p;
      expected_results.push_back(make_result(ep, 8'h00, 1'b0, 1'b1, len, p, ep[0],
         1'b0, 8'h00));
   endfunction

   function automatic void stream_reply(logic [7:0] bytes [64], int full_len, int wlen);
      int n;
      logic p;
      result_type r;
      n = full_len;
      if (n > wlen) n = wlen;
      if (n > 64) n = 64;
      if (n == 0) begin
         arm_endpoint(EP_EP0_IN, 7'd0);
         return;
      end
      p = toggle[1];
      toggle[1] = ~p;
      for (int i = 0; i < n; i++) begin
         r = make_result(EP_EP0_IN, bytes[i], 1'b1, 1'b0, 7'd0, 1'b0, 1'b0, 1'b0, 8'h00);
         if (i == n - 1) begin
            r.arm_buffer = 1'b1; r.transfer_length = 7'(n); r.data_pid = p;
            r.buffer_full = 1'b1;
         end else begin
            r.last = 1'b0;
         end
         expected_results.push_back(r);
      end
   endfunction

   function automatic void predict_descriptor(logic [15:0] value, int wlen);
      logic [7:0] b [64];
      logic [7:0] dev [18];
      logic [7:0] cfg [32];
      logic [7:0] kind, idx;
      int n, chars;
      logic [7:0] text [5][8];
      int text_len [5];
      text[0] = '{8'h50, 8'h69, 8'h63, 8'h6f, 8'h55, 8'h53, 8'h42, 8'h00};
      text[1] = '{8'h44, 8'h65, 8'h6d, 8'h6f, 8'h00, 8'h00, 8'h00, 8'h00};
      text[2] = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h00, 8'h00, 8'h00};
      text[3] = '{8'h45, 8'h61, 8'h73, 8'h79, 8'h00, 8'h00, 8'h00, 8'h00};
      text[4] = '{8'h53, 8'h69, 8'h6d, 8'h70, 8'h6c, 8'h65, 8'h00, 8'h00};
      text_len = '{7, 4, 5, 4, 6};
      foreach (b[i]) b[i] = 8'h00;
      kind = value[15:8];
      idx = value[7:0];
      if (kind == DESC_DEVICE) begin
         dev = '{8'd18, 8'h01, 8'h00, 8'h02, 8'h00, 8'h00, 8'h00, 8'd64,
            vid[7:0], vid[15:8], pid_reg[7:0], pid_reg[15:8],
            release_bcd[7:0], release_bcd[15:8], 8'd1, 8'd2, 8'd3, 8'd1};
         for (int i = 0; i < 18; i++) b[i] = dev[i];
         n = 18;
      end else if (kind == DESC_CONFIG) begin
         cfg = '{8'd9, 8'h02, 8'd32, 8'h00, 8'd1, 8'd1, 8'd4, attr_byte, power_byte,
            8'd9, 8'h04, 8'h00, 8'h00, 8'd2, 8'hff, 8'h00, 8'h00, 8'd5,
            8'd7, 8'h05, 8'h01, 8'h02, 8'd64, 8'h00, 8'h00,
            8'd7, 8'h05, 8'h82, 8'h02, 8'd64, 8'h00, 8'h00};
         for (int i = 0; i < 32; i++) b[i] = cfg[i];
         n = 32;
      end else if (kind == DESC_STRING) begin
         if (idx == 8'd0) begin
            b[0] = 8'd4; b[1] = 8'h03; b[2] = 8'h09; b[3] = 8'h04;
            n = 4;
         end else begin
            if (idx > 8'd5) return;
            chars = text_len[idx - 1];
            n = 2 + 2 * chars;
            b[0] = 8'(n); b[1] = 8'h03;
            for (int i = 0; i < chars; i++) b[2 + 2 * i] = text[idx - 1][i];
         end
      end else begin
         return;
      end
      stream_reply(b, n, wlen);
   endfunction

   function automatic void predict_responses(request_item it);
      logic [7:0] one [64];
      case (action_type'(it.action))
         ACT_SETUP: begin
            toggle[1] = 1'b1;
            if (it.request_type == RT_HOST_TO_DEV) begin
               if (it.request_code == REQ_SET_ADDRESS) begin
                  saved_address = it.request_value[7:0];
                  address_waiting = 1'b1;
               end else if (it.request_code == REQ_SET_CONFIGURATION) begin
                  is_configured = 1'b1;
               end
               arm_endpoint(EP_EP0_IN, 7'd0);
            end else if (it.request_type == RT_DEV_TO_HOST) begin
               if (it.request_code == REQ_GET_DESCRIPTOR) begin
                  predict_descriptor(it.request_value, it.length_requested);
               end else if (it.request_code == REQ_GET_CONFIGURATION) begin
                  foreach (one[i]) one[i] = 8'h00;
                  one[0] = 8'd1;
                  stream_reply(one, 1, it.length_requested);
               end
            end
         end
         ACT_BUS_RESET: begin
            saved_address = 8'h00;
            address_waiting = 1'b0;
            is_configured = 1'b0;
            expected_results.push_back(make_result(EP_EP0_OUT, 8'h00, 1'b0, 1'b0, 7'd0,
               1'b0, 1'b0, 1'b1, 8'h00));
         end
         ACT_EP0_IN_DONE: begin
            if (address_waiting) begin
               address_waiting = 1'b0;
               expected_results.push_back(make_result(EP_EP0_IN, 8'h00, 1'b0, 1'b0, 7'd0,
                  1'b0, 1'b0, 1'b1, saved_address));
            end else begin
               arm_endpoint(EP_EP0_OUT, 7'd0);
            end
         end
         ACT_BULK_OUT_DONE:
            arm_endpoint(EP_BULK_IN, it.received_length > 7'd64 ? 7'd64 : it.received_length);
         ACT_BULK_IN_DONE, ACT_ARM_BULK_OUT: arm_endpoint(EP_BULK_OUT, 7'd64);
         default: ;
      endcase
   endfunction

   function automatic int random_gap();
      if ($urandom_range(0, 3) != 0) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   // Request driver.
   int send_gap = 0;
   always @(negedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
      end else if (req.valid && !req_accepted) begin
      end else if (send_gap > 0) begin
         send_gap <= send_gap - 1;
         req.valid <= 1'b0;
      end else if (pending_requests.size() > 0 && !hold_requests) begin
         request_item it;
         it = pending_requests.pop_front();
         req.valid <= 1'b1;
         req.action <= it.action;
         req.request_type <= it.request_type;
         req.request_code <= it.request_code;
         req.request_value <= it.request_value;
         req.length_requested <= it.length_requested;
         req.received_length <= it.received_length;
         send_gap <= random_gap();
      end else begin
         req.valid <= 1'b0;
      end
   end

   // Response sink readiness.
   int stall_count = 0;
   always @(negedge clock) begin
      if (stall_count > 0) begin
         stall_count <= stall_count - 1;
         rsp.ready <= 1'b0;
      end else begin
         stall_count <= random_gap();
         rsp.ready <= 1'b1;
      end
   end

   // Monitor: predict on request acceptance, check on response acceptance.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      req_accepted <= !reset && req.valid && req.ready;
      if (!reset && req.valid && req.ready) begin
         request_item it;
         it = '{req.action, req.request_type, req.request_code, req.request_value,
            req.length_requested, req.received_length};
         predict_responses(it);
      end
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_results.size() == 0) begin
            $error("response item with nothing expected");
            errors++;
         end else begin
            result_type e;
            e = expected_results.pop_front();
            if (rsp.endpoint !== e.endpoint) begin
               $error("endpoint exp %0d got %0d", e.endpoint, rsp.endpoint); errors++; end
            if (rsp.data_byte !== e.data_byte) begin
               $error("data_byte exp %0h got %0h", e.data_byte, rsp.data_byte); errors++; end
            if (rsp.byte_valid !== e.byte_valid) begin
               $error("byte_valid exp %0d got %0d", e.byte_valid, rsp.byte_valid); errors++; end
            if (rsp.arm_buffer !== e.arm_buffer) begin
               $error("arm_buffer exp %0d got %0d", e.arm_buffer, rsp.arm_buffer); errors++; end
            if (rsp.transfer_length !== e.transfer_length) begin
               $error("transfer_length exp %0d got %0d", e.transfer_length,
                  rsp.transfer_length);
               errors++;
            end
            if (rsp.data_pid !== e.data_pid) begin
               $error("data_pid exp %0d got %0d", e.data_pid, rsp.data_pid); errors++; end
            if (rsp.buffer_full !== e.buffer_full) begin
               $error("buffer_full exp %0d got %0d", e.buffer_full, rsp.buffer_full);
               errors++;
            end
            if (rsp.address_apply !== e.address_apply) begin
               $error("address_apply exp %0d got %0d", e.address_apply, rsp.address_apply);
               errors++;
            end
            if (rsp.dev_addr !== e.dev_addr) begin
               $error("dev_addr exp %0h got %0h", e.dev_addr, rsp.dev_addr);
               errors++;
            end
            if (rsp.configured !== e.configured) begin
               $error("configured exp %0d got %0d", e.configured, rsp.configured); errors++; end
            if (rsp.last !== e.last) begin
               $error("last exp %0d got %0d", e.last, rsp.last); errors++; end
         end
      end
      if (cycle_count > 4000000) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic write_register(logic [2:0] idx, logic [15:0] value);
      @(negedge clock);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= value;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      case (idx)
         CSR_VENDOR_ID: vid = value;
         CSR_PRODUCT_ID: pid_reg = value;
         CSR_DEVICE_RELEASE: release_bcd = value;
         CSR_CONFIG_ATTR: attr_byte = value[7:0];
         CSR_MAX_POWER: power_byte = value[7:0];
         default: ;
      endcase
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   task automatic drain();
      while (pending_requests.size() > 0 || req.valid || expected_results.size() > 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic request_item setup_item(logic [7:0] rt, logic [7:0] code,
      logic [15:0] value, logic [15:0] wlen);
      return '{ACT_SETUP, rt, code, value, wlen, 7'($urandom_range(0, 127))};
   endfunction

   function automatic request_item event_item(action_type a, logic [6:0] rlen);
      return '{a, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), rlen};
   endfunction

   function automatic request_item random_request();
      int pick;
      logic [15:0] value;
      logic [15:0] wlen;
      pick = $urandom_range(0, 99);
      wlen = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 70));
      if (pick < 40) begin
         case ($urandom_range(0, 3))
            0: value = {DESC_DEVICE, 8'($urandom)};
            1: value = {DESC_CONFIG, 8'($urandom)};
            2: value = {DESC_STRING, 8'($urandom_range(0, 5))};
            default: value = 16'($urandom);
         endcase
         return setup_item(RT_DEV_TO_HOST, REQ_GET_DESCRIPTOR, value, wlen);
      end
      if (pick < 45) return setup_item(RT_DEV_TO_HOST, REQ_GET_CONFIGURATION, 16'($urandom),
         wlen);
      if (pick < 55) return setup_item(RT_HOST_TO_DEV, REQ_SET_ADDRESS, 16'($urandom), wlen);
      if (pick < 60) return setup_item(RT_HOST_TO_DEV, REQ_SET_CONFIGURATION,
         16'($urandom), wlen);
      if (pick < 65) return setup_item(8'($urandom), 8'($urandom), 16'($urandom),
         16'($urandom));
      if (pick < 75) return event_item(ACT_EP0_IN_DONE, 7'($urandom));
      if (pick < 82) return event_item(ACT_BULK_OUT_DONE, 7'($urandom_range(0, 127)));
      if (pick < 88) return event_item(ACT_BULK_IN_DONE, 7'($urandom));
      if (pick < 93) return event_item(ACT_ARM_BULK_OUT, 7'($urandom));
      if (pick < 97) return event_item(ACT_BUS_RESET, 7'($urandom));
      return event_item(action_type'($urandom_range(6, 7)), 7'($urandom));
   endfunction

   initial begin
      req.valid = 1'b0; req.action = '0; req.request_type = '0; req.request_code = '0;
      req.request_value = '0; req.length_requested = '0; req.received_length = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0; csr.index = '0; csr.data = '0;
      foreach (toggle[i]) toggle[i] = 1'b0;
      saved_address = 8'h00; address_waiting = 1'b0; is_configured = 1'b0;
      vid = 16'd0; pid_reg = 16'd1; release_bcd = 16'd1; attr_byte = 8'hc0;
      power_byte = 8'd50;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      pending_requests.push_back(setup_item(RT_DEV_TO_HOST, REQ_GET_DESCRIPTOR,
         {DESC_DEVICE, 8'h00}, 16'hffff));
      pending_requests.push_back(setup_item(RT_DEV_TO_HOST, REQ_GET_DESCRIPTOR,
         {DESC_CONFIG, 8'h00}, 16'd0));
      pending_requests.push_back(setup_item(RT_DEV_TO_HOST, REQ_GET_DESCRIPTOR,
         {DESC_CONFIG, 8'h00}, 16'd9));
      for (int s = 0; s <= 6; s++)
         pending_requests.push_back(setup_item(RT_DEV_TO_HOST, REQ_GET_DESCRIPTOR,
            {DESC_STRING, 8'(s)}, 16'd255));
      pending_requests.push_back(setup_item(RT_DEV_TO_HOST, REQ_GET_DESCRIPTOR,
         16'hff00, 16'd64));
      pending_requests.push_back(setup_item(RT_DEV_TO_HOST, REQ_GET_CONFIGURATION, 16'd0,
         16'd1));
      pending_requests.push_back(setup_item(RT_HOST_TO_DEV, REQ_SET_ADDRESS, 16'h00ff,
         16'd0));
      pending_requests.push_back(event_item(ACT_EP0_IN_DONE, 7'd0));
      pending_requests.push_back(event_item(ACT_EP0_IN_DONE, 7'd0));
      pending_requests.push_back(setup_item(RT_HOST_TO_DEV, REQ_SET_CONFIGURATION, 16'd1,
         16'd0));
      pending_requests.push_back(setup_item(8'hff, 8'hff, 16'hffff, 16'hffff));
      pending_requests.push_back(event_item(ACT_BULK_OUT_DONE, 7'd127));
      pending_requests.push_back(event_item(ACT_BULK_OUT_DONE, 7'd0));
      pending_requests.push_back(event_item(ACT_BULK_IN_DONE, 7'd0));
      pending_requests.push_back(event_item(ACT_ARM_BULK_OUT, 7'd0));
      pending_requests.push_back(event_item(ACT_RSVD6, 7'd0));
      pending_requests.push_back(event_item(ACT_RSVD7, 7'd0));
      pending_requests.push_back(event_item(ACT_BUS_RESET, 7'd0));
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               write_register(CSR_VENDOR_ID, 16'hffff);
               write_register(CSR_PRODUCT_ID, 16'hffff);
               write_register(CSR_DEVICE_RELEASE, 16'hffff);
               write_register(CSR_CONFIG_ATTR, 16'h00ff);
               write_register(CSR_MAX_POWER, 16'h00ff);
            end
            1: begin
               write_register(CSR_VENDOR_ID, 16'h0000);
               write_register(CSR_PRODUCT_ID, 16'h0000);
               write_register(CSR_DEVICE_RELEASE, 16'h0000);
               write_register(CSR_CONFIG_ATTR, 16'h0000);
               write_register(CSR_MAX_POWER, 16'h0000);
            end
            default: begin
               write_register(CSR_VENDOR_ID, 16'($urandom));
               write_register(CSR_PRODUCT_ID, 16'($urandom));
               write_register(CSR_DEVICE_RELEASE, 16'($urandom));
               write_register(CSR_CONFIG_ATTR, 16'($urandom_range(0, 255)));
               write_register(CSR_MAX_POWER, 16'($urandom_range(0, 255)));
            end
         endcase
         for (int i = 0; i < 32; i++) pending_requests.push_back(random_request());
         while (pending_requests.size() > 0) @(posedge clock);
         // Hold the sender until the block has answered everything.
         hold_requests = 1'b1;
         while (req.valid || expected_results.size() > 0) @(posedge clock);
         hold_requests = 1'b0;
         for (int i = 0; i < 32; i++) pending_requests.push_back(random_request());
         drain();
      end

      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule

// ===== files.f =====
rtl/ucrr_pkg.sv
rtl/ucrr_if.sv
rtl/ucrr_ctrl.sv
rtl/ucrr_datapath.sv
rtl/usb_control_request_responder.sv
tb/tb_usb_control_request_responder.sv
